// ===== rtl/cap_pkg.sv =====
// ----------------------------------------------------------------------------
// cap_pkg
// Types and constants shared by the cell address parser modules.
// ----------------------------------------------------------------------------
package cap_pkg;

	localparam int ROW_W     = 21;
	localparam int COLUMN_W  = 15;
	localparam int ROW_ACC_W = 24;
	localparam int LETTER_W  = 2;
	localparam int DIGIT_W   = 3;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 21;

	localparam logic [ROW_W-1:0]    ROW_LIMIT    = 21'd1048576;
	localparam logic [COLUMN_W-1:0] COLUMN_LIMIT = 15'd16384;
	localparam logic [LETTER_W-1:0] LETTERS_MAX  = 2'd3;
	localparam logic [DIGIT_W-1:0]  DIGITS_MAX   = 3'd7;

	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_NINE    = 8'h39;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAX_ROW    = 1'b0,
		CFG_MAX_COLUMN = 1'b1
	} cfg_idx_t;

	// parse totals of one finished address
	typedef struct packed {
		logic [ROW_ACC_W-1:0] row;
		logic [COLUMN_W-1:0]  column;
		logic [LETTER_W-1:0]  letters;
		logic [DIGIT_W-1:0]   digits;
		logic                 malformed;
	} snap_t;

endpackage

// ===== rtl/cap_scan.sv =====
// ----------------------------------------------------------------------------
// cap_scan
// Character input register, running parse state and the snapshot register
// that holds the totals of each finished address.
// ----------------------------------------------------------------------------
module cap_scan (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          char_code,
	input  logic                last_char,
	input  logic                check_free,
	output logic                snap_valid,
	output cap_pkg::snap_t      snap
);

	logic                           valid_s1;
	logic [7:0]                     char_s1;
	logic                           last_s1;
	logic                           s1_take;
	logic                           s1_move;
	logic                           s2_free;

	logic [cap_pkg::ROW_ACC_W-1:0]  row_q;
	logic [cap_pkg::COLUMN_W-1:0]   column_q;
	logic [cap_pkg::LETTER_W-1:0]   letters_q;
	logic [cap_pkg::DIGIT_W-1:0]    digits_q;
	logic                           in_digits_q;
	logic                           malformed_q;

	logic                           is_letter;
	logic                           is_digit;
	logic [19:0]                    column_prod;
	logic [27:0]                    row_prod;
	cap_pkg::snap_t                 upd;
	logic                           upd_in_digits;

	logic                           valid_s2;
	cap_pkg::snap_t                 snap_s2;

	assign s2_free  = !valid_s2 || check_free;
	assign s1_move  = valid_s1 && (!last_s1 || s2_free);
	assign in_stall = valid_s1 && !s1_move;
	assign s1_take  = in_valid && !in_stall;

	assign column_prod = 20'(column_q) * 20'd26;
	assign row_prod    = 28'(row_q) * 28'd10;

	always_comb begin
		is_letter = char_s1 inside {[cap_pkg::CHAR_UPPER_A:cap_pkg::CHAR_UPPER_Z]};
		is_digit  = char_s1 inside {[cap_pkg::CHAR_ZERO:cap_pkg::CHAR_NINE]};

		upd.row       = row_q;
		upd.column    = column_q;
		upd.letters   = letters_q;
		upd.digits    = digits_q;
		upd.malformed = malformed_q;
		upd_in_digits = in_digits_q;

		if (is_letter) begin
			if (in_digits_q || letters_q == cap_pkg::LETTERS_MAX) begin
				upd.malformed = 1'b1;
			end else begin
				// low five bits of an upper-case letter give A=1 .. Z=26
				upd.column  = column_prod[cap_pkg::COLUMN_W-1:0]
				            + {{(cap_pkg::COLUMN_W-5){1'b0}}, char_s1[4:0]};
				upd.letters = letters_q + 2'd1;
			end
		end else if (is_digit) begin
			upd_in_digits = 1'b1;
			if (digits_q == cap_pkg::DIGITS_MAX) begin
				upd.malformed = 1'b1;
			end else begin
				upd.row    = row_prod[cap_pkg::ROW_ACC_W-1:0]
				           + {{(cap_pkg::ROW_ACC_W-4){1'b0}}, char_s1[3:0]};
				upd.digits = digits_q + 3'd1;
			end
		end else begin
			upd.malformed = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_take) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_take) begin
			char_s1 <= char_code;
			last_s1 <= last_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= '0;
			column_q    <= '0;
			letters_q   <= '0;
			digits_q    <= '0;
			in_digits_q <= 1'b0;
			malformed_q <= 1'b0;
		end else if (s1_move) begin
			if (last_s1) begin
				row_q       <= '0;
				column_q    <= '0;
				letters_q   <= '0;
				digits_q    <= '0;
				in_digits_q <= 1'b0;
				malformed_q <= 1'b0;
			end else begin
				row_q       <= upd.row;
				column_q    <= upd.column;
				letters_q   <= upd.letters;
				digits_q    <= upd.digits;
				in_digits_q <= upd_in_digits;
				malformed_q <= upd.malformed;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_move && last_s1) begin
			valid_s2 <= 1'b1;
		end else if (check_free) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && last_s1) begin
			snap_s2 <= upd;
		end
	end

	assign snap_valid = valid_s2;
	assign snap       = snap_s2;

endmodule

// ===== rtl/cap_check.sv =====
// ----------------------------------------------------------------------------
// cap_check
// Checks the totals of a finished address against counts and limits and
// holds the result in the output register.
// ----------------------------------------------------------------------------
module cap_check (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          snap_valid,
	input  cap_pkg::snap_t                snap,
	output logic                          check_free,
	input  logic [cap_pkg::ROW_W-1:0]     max_row,
	input  logic [cap_pkg::COLUMN_W-1:0]  max_column,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [cap_pkg::ROW_W-1:0]     row_number,
	output logic [cap_pkg::COLUMN_W-1:0]  column_number,
	output logic                          address_valid
);

	logic                          ok;
	logic                          load;
	logic                          out_valid_q;
	logic [cap_pkg::ROW_W-1:0]     row_q;
	logic [cap_pkg::COLUMN_W-1:0]  column_q;
	logic                          ok_q;

	assign check_free = !out_valid_q || !out_stall;
	assign load       = snap_valid && check_free;

	// letter and digit counters stop at their maximum and flag the address malformed, so they need only a lower-bound test
	always_comb begin
		ok = !snap.malformed
		  && snap.letters != '0
		  && snap.digits != '0
		  && snap.row != '0
		  && snap.row <= cap_pkg::ROW_ACC_W'(max_row)
		  && snap.row <= cap_pkg::ROW_ACC_W'(cap_pkg::ROW_LIMIT)
		  && snap.column != '0
		  && snap.column <= max_column
		  && snap.column <= cap_pkg::COLUMN_LIMIT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			row_q    <= ok ? snap.row[cap_pkg::ROW_W-1:0] : '0;
			column_q <= ok ? snap.column : '0;
			ok_q     <= ok;
		end
	end

	assign out_valid     = out_valid_q;
	assign row_number    = row_q;
	assign column_number = column_q;
	assign address_valid = ok_q;

endmodule

// ===== rtl/cell_address_parser.sv =====
// ----------------------------------------------------------------------------
// cell_address_parser
// Path of a result: the last char is taken into the input register, the parse
// update loads the snapshot register, which then loads the output register.
// Throughput: one character per cycle; the input stalls only while a finished
// address waits behind a held result.
// Reset: clears the parse state and all valids, limits return to 1048576/16384.
// ----------------------------------------------------------------------------
module cell_address_parser (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [7:0]                     char_code,
	input  logic                           last_char,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [cap_pkg::ROW_W-1:0]      row_number,
	output logic [cap_pkg::COLUMN_W-1:0]   column_number,
	output logic                           address_valid,
	input  logic                           cfg_write,
	input  logic [cap_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cap_pkg::CFG_W-1:0]      cfg_data
);

	logic [cap_pkg::ROW_W-1:0]     max_row_q;
	logic [cap_pkg::COLUMN_W-1:0]  max_column_q;
	logic                          check_free;
	logic                          snap_valid;
	cap_pkg::snap_t                snap;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_row_q    <= cap_pkg::ROW_LIMIT;
			max_column_q <= cap_pkg::COLUMN_LIMIT;
		end else if (cfg_write) begin
			case (cfg_index)
				cap_pkg::CFG_MAX_ROW: begin
					max_row_q <= cfg_data[cap_pkg::ROW_W-1:0];
				end
				cap_pkg::CFG_MAX_COLUMN: begin
					max_column_q <= cfg_data[cap_pkg::COLUMN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	cap_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.char_code  (char_code),
		.last_char  (last_char),
		.check_free (check_free),
		.snap_valid (snap_valid),
		.snap       (snap)
	);

	cap_check u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.snap_valid    (snap_valid),
		.snap          (snap),
		.check_free    (check_free),
		.max_row       (max_row_q),
		.max_column    (max_column_q),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.row_number    (row_number),
		.column_number (column_number),
		.address_valid (address_valid)
	);

	// a valid address never reports a zero coordinate
	a_valid_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && address_valid |-> row_number != '0 && column_number != '0)
		else $error("valid address with zero row or column");

	// an invalid address reports zeros
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !address_valid |-> row_number == '0 && column_number == '0)
		else $error("invalid address with nonzero row or column");

	// a finished address waiting on a full output register is kept
	a_snap_held: assert property (@(posedge clk) disable iff (!arst_n)
		snap_valid && !check_free |=> snap_valid && $stable(snap))
		else $error("waiting address totals lost");

	// input is held off only while the output side is held off
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall && snap_valid)
		else $error("input stalled with a free output path");

endmodule
